[sv/tct_pkg.sv]
// Shared types and constants of the text console teletype.
// Used by the controller, the datapath and the top level; no dependencies.
package tct_pkg;

    localparam int CHAR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int PAGE_W     = 3;
    localparam int CELL_IDX_W = 16;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_LINEFEED  = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_BELL      = 8'h07;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [CHAR_W-1:0] BLANK_ATTR   = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL   = {BLANK_ATTR, SPACE_CODE};

    // A 40-column mode uses 1024-cell pages, every other width 2048-cell pages.
    localparam logic [COL_W-1:0] NARROW_COLUMNS    = 7'd40;
    localparam int               NARROW_PAGE_SHIFT = 10;
    localparam int               WIDE_PAGE_SHIFT   = 11;

    // Cells that come out of reset holding a blank (one 80x25 page).
    localparam int RESET_BLANK_CELLS = 2000;

    localparam logic [COL_W-1:0]  COLUMNS_RESET  = 7'd80;
    localparam logic [ROW_W-1:0]  ROWS_RESET     = 5'd25;
    localparam logic [PAGE_W-1:0] PAGE_SEL_RESET = 3'd0;

    localparam logic [1:0] REG_COLUMNS  = 2'd0;
    localparam logic [1:0] REG_ROWS     = 2'd1;
    localparam logic [1:0] REG_PAGE_SEL = 2'd2;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic char_wr;
        logic scr_rd;
        logic scr_wr;
        logic blank_wr;
        logic commit;
    } tct_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_print;
        logic do_scroll;
        logic rows_one;
        logic copy_last;
        logic blank_last;
    } tct_status_t;

endpackage

[sv/tct_ctrl.sv]
// Sequencing state machine of the text console teletype.
// Depends on tct_pkg; drives tct_datapath through command and status structs.
module tct_ctrl
    import tct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  tct_status_t st,
    output tct_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PRINT,
        S_SCR_RD,
        S_SCR_WR,
        S_BLANK,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (st.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PRINT;
                end
            end
            S_PRINT:
            begin
                cmd.char_wr = st.is_print;
                if (!st.do_scroll)
                begin
                    state_next = S_FINISH;
                end
                else if (st.rows_one)
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    state_next = S_SCR_RD;
                end
            end
            S_SCR_RD:
            begin
                cmd.scr_rd = 1'b1;
                state_next = S_SCR_WR;
            end
            S_SCR_WR:
            begin
                cmd.scr_wr = 1'b1;
                state_next = st.copy_last ? S_BLANK : S_SCR_RD;
            end
            S_BLANK:
            begin
                cmd.blank_wr = 1'b1;
                if (st.blank_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[sv/tct_datapath.sv]
// Datapath of the text console teletype: screen memory, per-page cursors,
// scroll address counters and the result register. Depends on tct_pkg.
module tct_datapath
    import tct_pkg::*;
#(
    parameter int PAGES      = 8,
    parameter int VRAM_CELLS = 8192
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tct_cmd_t          cmd,
    output tct_status_t       st,
    input  logic [COL_W-1:0]  columns,
    input  logic [ROW_W-1:0]  rows,
    input  logic [PAGE_W-1:0] page_sel,
    input  logic [CHAR_W-1:0] character,
    input  logic [CHAR_W-1:0] attribute,
    output logic [ROW_W-1:0]  row_pos,
    output logic [COL_W-1:0]  col_pos,
    output logic              scrolled
);

    localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW = $clog2(VRAM_CELLS);

    localparam logic [CELL_IDX_W-1:0] VRAM_LIMIT = CELL_IDX_W'(VRAM_CELLS);

    // Screen memory, one port, registered read.
    logic [CELL_W-1:0] vram [VRAM_CELLS];
    logic [AW-1:0]     mem_addr;
    logic              mem_we;
    logic [CELL_W-1:0] mem_wdata;
    logic [CELL_W-1:0] mem_rdata;

    logic [ROW_W-1:0] cur_rows_reg [PAGES];
    logic [COL_W-1:0] cur_cols_reg [PAGES];

    logic [AW-1:0]         clr_reg;
    logic [PW-1:0]         page_reg;
    logic [COL_W-1:0]      ncols_reg;
    logic [ROW_W-1:0]      nrows_reg;
    logic [CELL_IDX_W-1:0] char_idx_reg;
    logic [CELL_W-1:0]     cell_data_reg;
    logic                  print_reg;
    logic                  scroll_reg;
    logic [ROW_W-1:0]      fin_row_reg;
    logic [COL_W-1:0]      fin_col_reg;
    logic [CELL_IDX_W-1:0] dst_reg;
    logic [COL_W-1:0]      cnt_col_reg;
    logic [ROW_W-1:0]      cnt_row_reg;
    logic                  src_oob_reg;
    logic [ROW_W-1:0]      out_row_reg;
    logic [COL_W-1:0]      out_col_reg;
    logic                  out_scr_reg;

    // Decode of the incoming beat against the active page's cursor.
    logic [COL_W-1:0]      ncols;
    logic [ROW_W-1:0]      nrows;
    logic [PW-1:0]         pg;
    logic [ROW_W-1:0]      row0;
    logic [COL_W-1:0]      col0;
    logic                  is_bs;
    logic                  is_cr;
    logic                  is_lf;
    logic                  is_print;
    logic [COL_W:0]        col_inc;
    logic                  wrap;
    logic [ROW_W:0]        row_n;
    logic [COL_W:0]        col_n;
    logic                  need_scroll;
    logic [ROW_W-1:0]      row_f;
    logic [COL_W-1:0]      col_f;
    logic [CELL_IDX_W-1:0] page_base;
    logic [11:0]           row_off;
    logic [CELL_IDX_W-1:0] char_idx;
    logic [CELL_IDX_W-1:0] src_idx;
    logic                  row_end;

    always_comb
    begin
        ncols = (columns == '0) ? COL_W'(1) : columns;
        nrows = (rows == '0) ? ROW_W'(1) : rows;
        pg    = (4'(page_sel) < 4'(PAGES)) ? page_sel[PW-1:0] : '0;
        row0  = cur_rows_reg[pg];
        col0  = cur_cols_reg[pg];

        is_bs    = (character == CH_BACKSPACE);
        is_cr    = (character == CH_RETURN);
        is_lf    = (character == CH_LINEFEED);
        is_print = !is_bs && !is_cr && !is_lf && (character != CH_BELL);

        col_inc = {1'b0, col0} + (COL_W+1)'(1);
        wrap    = (col_inc >= {1'b0, ncols});

        if (is_lf || (is_print && wrap))
        begin
            row_n = {1'b0, row0} + (ROW_W+1)'(1);
        end
        else
        begin
            row_n = {1'b0, row0};
        end

        if (is_bs)
        begin
            col_n = (col0 != '0) ? {1'b0, col0 - COL_W'(1)} : {1'b0, col0};
        end
        else if (is_cr)
        begin
            col_n = '0;
        end
        else if (is_print)
        begin
            col_n = wrap ? '0 : col_inc;
        end
        else
        begin
            col_n = {1'b0, col0};
        end

        need_scroll = (row_n >= {1'b0, nrows});
        row_f = need_scroll ? (nrows - ROW_W'(1)) : row_n[ROW_W-1:0];
        col_f = (col_n >= {1'b0, ncols}) ? (ncols - COL_W'(1)) : col_n[COL_W-1:0];

        if (columns == NARROW_COLUMNS)
        begin
            page_base = CELL_IDX_W'(pg) << NARROW_PAGE_SHIFT;
        end
        else
        begin
            page_base = CELL_IDX_W'(pg) << WIDE_PAGE_SHIFT;
        end
        row_off  = 12'(row0) * 12'(ncols);
        char_idx = page_base + CELL_IDX_W'(row_off) + CELL_IDX_W'(col0);
    end

    // Scroll copy reads one row below the cell being rewritten.
    assign src_idx = dst_reg + CELL_IDX_W'(ncols_reg);
    assign row_end = (cnt_col_reg == ncols_reg - COL_W'(1));

    always_comb
    begin
        st.clear_last = (clr_reg == AW'(VRAM_CELLS - 1));
        st.is_print   = print_reg;
        st.do_scroll  = scroll_reg;
        st.rows_one   = (nrows_reg == ROW_W'(1));
        st.copy_last  = row_end && (cnt_row_reg == nrows_reg - ROW_W'(2));
        st.blank_last = row_end;
    end

    always_comb
    begin
        mem_addr  = dst_reg[AW-1:0];
        mem_wdata = BLANK_CELL;
        mem_we    = 1'b0;
        if (cmd.clear_wr)
        begin
            mem_addr  = clr_reg;
            mem_wdata = (CELL_IDX_W'(clr_reg) < CELL_IDX_W'(RESET_BLANK_CELLS))
                      ? BLANK_CELL : '0;
            mem_we    = 1'b1;
        end
        else if (cmd.char_wr)
        begin
            mem_addr  = char_idx_reg[AW-1:0];
            mem_wdata = cell_data_reg;
            mem_we    = (char_idx_reg < VRAM_LIMIT);
        end
        else if (cmd.scr_rd)
        begin
            mem_addr = src_idx[AW-1:0];
        end
        else if (cmd.scr_wr)
        begin
            mem_wdata = src_oob_reg ? BLANK_CELL : mem_rdata;
            mem_we    = (dst_reg < VRAM_LIMIT);
        end
        else if (cmd.blank_wr)
        begin
            mem_we = (dst_reg < VRAM_LIMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vram[mem_addr] <= mem_wdata;
        end
        else
        begin
            mem_rdata <= vram[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAGES; i++)
            begin
                cur_rows_reg[i] <= '0;
                cur_cols_reg[i] <= '0;
            end
            clr_reg     <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            out_scr_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.commit)
            begin
                cur_rows_reg[page_reg] <= fin_row_reg;
                cur_cols_reg[page_reg] <= fin_col_reg;
                out_row_reg            <= fin_row_reg;
                out_col_reg            <= fin_col_reg;
                out_scr_reg            <= scroll_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg      <= pg;
            ncols_reg     <= ncols;
            nrows_reg     <= nrows;
            char_idx_reg  <= char_idx;
            cell_data_reg <= {attribute, character};
            print_reg     <= is_print;
            scroll_reg    <= need_scroll;
            fin_row_reg   <= row_f;
            fin_col_reg   <= col_f;
            dst_reg       <= page_base;
            cnt_col_reg   <= '0;
            cnt_row_reg   <= '0;
        end
        if (cmd.scr_rd)
        begin
            src_oob_reg <= (src_idx >= VRAM_LIMIT);
        end
        if (cmd.scr_wr || cmd.blank_wr)
        begin
            dst_reg <= dst_reg + CELL_IDX_W'(1);
            if (row_end)
            begin
                cnt_col_reg <= '0;
                cnt_row_reg <= cnt_row_reg + ROW_W'(1);
            end
            else
            begin
                cnt_col_reg <= cnt_col_reg + COL_W'(1);
            end
        end
    end

    assign row_pos  = out_row_reg;
    assign col_pos  = out_col_reg;
    assign scrolled = out_scr_reg;

endmodule

[sv/text_console_teletype.sv]
// Text console teletype: one result beat per character beat.
// When the page scrolls, the rows are copied up one row and the last row is blanked
// over the single memory port before the result beat is given.
// A new character is accepted only once the previous result has been committed.
// Reset: asynchronous, active low; a clearing pass over all VRAM_CELLS cells then
// follows, during which no character is accepted (configuration writes still are).
module text_console_teletype
    import tct_pkg::*;
#(
    parameter int PAGES      = 8,
    parameter int VRAM_CELLS = 8192
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] character,
    input  logic [CHAR_W-1:0] attribute,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ROW_W-1:0]  row_pos,
    output logic [COL_W-1:0]  col_pos,
    output logic              scrolled
);

    logic [COL_W-1:0]  columns_reg;
    logic [COL_W-1:0]  columns_next;
    logic [ROW_W-1:0]  rows_reg;
    logic [ROW_W-1:0]  rows_next;
    logic [PAGE_W-1:0] page_reg;
    logic [PAGE_W-1:0] page_next;
    logic              wr_en;
    tct_cmd_t          cmd;
    tct_status_t       st;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        columns_next = columns_reg;
        rows_next    = rows_reg;
        page_next    = page_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                REG_COLUMNS:  columns_next = pwdata[COL_W-1:0];
                REG_ROWS:     rows_next    = pwdata[ROW_W-1:0];
                REG_PAGE_SEL: page_next    = pwdata[PAGE_W-1:0];
                default:      columns_next = columns_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_COLUMNS:  prdata = 32'(columns_reg);
            REG_ROWS:     prdata = 32'(rows_reg);
            REG_PAGE_SEL: prdata = 32'(page_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RESET;
            rows_reg    <= ROWS_RESET;
            page_reg    <= PAGE_SEL_RESET;
        end
        else
        begin
            columns_reg <= columns_next;
            rows_reg    <= rows_next;
            page_reg    <= page_next;
        end
    end

    tct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    tct_datapath #(
        .PAGES      (PAGES),
        .VRAM_CELLS (VRAM_CELLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .columns   (columns_reg),
        .rows      (rows_reg),
        .page_sel  (page_reg),
        .character (character),
        .attribute (attribute),
        .row_pos   (row_pos),
        .col_pos   (col_pos),
        .scrolled  (scrolled)
    );

endmodule

[sv/tct_checker.sv]
// Port-level checks of the text console teletype, bound to the top level.
// Depends on tct_pkg for field widths.
module tct_checker
    import tct_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              pready,
    input logic [31:0]       prdata,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [ROW_W-1:0]  row_pos,
    input logic [COL_W-1:0]  col_pos,
    input logic              scrolled
);

    // Only one character is in flight: ready drops right after an accepted beat.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a character was in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(row_pos)
            && $stable(col_pos) && $stable(scrolled)))
        else $error("stalled result beat changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    // No register is wider than seven bits.
    a_prdata_upper: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:COL_W] == '0)
        else $error("read data has bits above the widest register");

endmodule

bind text_console_teletype tct_checker u_tct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .prdata    (prdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .row_pos   (row_pos),
    .col_pos   (col_pos),
    .scrolled  (scrolled)
);

[tb/text_console_teletype_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the text console teletype: a cursor scoreboard
// class plus tasks that drive the APB registers and the character stream.
// Depends on tct_pkg and text_console_teletype only.
module text_console_teletype_tb;
    import tct_pkg::*;

    typedef enum int {NO_IDLE, SENDER_IDLE, RECEIVER_STALL, BOTH_IDLE} idle_mode_t;

    // Tracks per-page cursors and the size registers, and holds the cursor
    // beats that the block still owes.
    class cursor_scoreboard;
        typedef struct packed {
            logic [ROW_W-1:0] row;
            logic [COL_W-1:0] column;
            logic             scrolled;
        } cursor_beat_t;

        int unsigned       columns;
        int unsigned       rows;
        logic [PAGE_W-1:0] page;
        logic [ROW_W-1:0]  row_of_page[8];
        logic [COL_W-1:0]  column_of_page[8];
        cursor_beat_t      pending_cursors[$];
        int                errors;

        function new();
            columns = 32'(COLUMNS_RESET);
            rows = 32'(ROWS_RESET);
            page = PAGE_SEL_RESET;
            foreach (row_of_page[i])
            begin
                row_of_page[i] = '0;
                column_of_page[i] = '0;
            end
            errors = 0;
        endfunction

        // Returns the value that a read of the register should give back.
        function logic [31:0] set_reg(input logic [1:0] idx, input logic [31:0] value);
            case (idx)
                REG_COLUMNS:
                begin
                    columns = 32'(value[COL_W-1:0]);
                    return columns;
                end
                REG_ROWS:
                begin
                    rows = 32'(value[ROW_W-1:0]);
                    return rows;
                end
                REG_PAGE_SEL:
                begin
                    page = value[PAGE_W-1:0];
                    return 32'(page);
                end
                default: return '0;
            endcase
        endfunction

        function cursor_beat_t advance_cursor(input logic [CHAR_W-1:0] code);
            int unsigned  ncols;
            int unsigned  nrows;
            int unsigned  r;
            int unsigned  c;
            cursor_beat_t beat;
            ncols = (columns != 0) ? columns : 1;
            nrows = (rows != 0) ? rows : 1;
            r = 32'(row_of_page[page]);
            c = 32'(column_of_page[page]);
            beat.scrolled = 1'b0;
            if (code == CH_BACKSPACE)
            begin
                if (c != 0)
                    c = c - 1;
            end
            else if (code == CH_RETURN)
                c = 0;
            else if (code == CH_LINEFEED)
                r = r + 1;
            else if (code != CH_BELL)
            begin
                c = c + 1;
                if (c >= ncols)
                begin
                    c = 0;
                    r = r + 1;
                end
            end
            if (r >= nrows)
            begin
                r = nrows - 1;
                beat.scrolled = 1'b1;
            end
            // A cursor left over from a larger page size ends up clamped.
            if (c >= ncols)
                c = ncols - 1;
            row_of_page[page] = r[ROW_W-1:0];
            column_of_page[page] = c[COL_W-1:0];
            beat.row = r[ROW_W-1:0];
            beat.column = c[COL_W-1:0];
            return beat;
        endfunction

        function void note_input(input logic [CHAR_W-1:0] code);
            pending_cursors.push_back(advance_cursor(code));
        endfunction

        function int outstanding();
            return pending_cursors.size();
        endfunction

        task report_mismatch(input string msg);
            if (errors < 100)
                $display("mismatch at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_result(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] column,
                          input logic scr);
            cursor_beat_t want;
            if (pending_cursors.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing pending: row %0d column %0d",
                                          row, column));
                return;
            end
            want = pending_cursors.pop_front();
            if (row !== want.row)
                report_mismatch($sformatf("row_pos %0d, wanted %0d", row, want.row));
            if (column !== want.column)
                report_mismatch($sformatf("col_pos %0d, wanted %0d",
                                          column, want.column));
            if (scr !== want.scrolled)
                report_mismatch($sformatf("scrolled %0b, wanted %0b", scr, want.scrolled));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_ready;
    logic [CHAR_W-1:0] character;
    logic [CHAR_W-1:0] attribute;
    logic              out_valid;
    logic              out_ready;
    logic [ROW_W-1:0]  row_pos;
    logic [COL_W-1:0]  col_pos;
    logic              scrolled;

    cursor_scoreboard book;
    int               send_idle_pct;
    int               recv_stall_pct;

    text_console_teletype dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .character (character),
        .attribute (attribute),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .row_pos   (row_pos),
        .col_pos   (col_pos),
        .scrolled  (scrolled)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            book.check_result(row_pos, col_pos, scrolled);

    initial
    begin
        #480_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            SENDER_IDLE:
            begin
                send_idle_pct = 78;
                recv_stall_pct = 0;
            end
            RECEIVER_STALL:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 78;
            end
            BOTH_IDLE:
            begin
                send_idle_pct = 32;
                recv_stall_pct = 32;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // Called right after the previous beat was accepted (or at start), so the
    // first falling edge either drops valid for a gap or presents the next beat.
    task automatic send_char(input logic [CHAR_W-1:0] code, input logic [CHAR_W-1:0] attr);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        character <= code;
        attribute <= attr;
        do
            @(posedge clk);
        while (!in_ready);
        book.note_input(code);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (book.outstanding() != 0)
            @(posedge clk);
    endtask

    // Write cycle followed straight by a read-back of the same register.
    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        logic [31:0] wdata;
        logic [31:0] readback;
        logic [31:0] stored;
        wdata = $urandom;
        case (idx)
            REG_COLUMNS: wdata[COL_W-1:0] = value[COL_W-1:0];
            REG_ROWS:    wdata[ROW_W-1:0] = value[ROW_W-1:0];
            default:     wdata[PAGE_W-1:0] = value[PAGE_W-1:0];
        endcase
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        stored = book.set_reg(idx, wdata);
        if (readback !== stored)
            book.report_mismatch($sformatf("register %0d reads %0h, wanted %0h",
                                           idx, readback, stored));
    endtask

    task automatic configure(input int unsigned cols, input int unsigned nrows,
                             input int unsigned pg);
        drain();
        write_reg(REG_COLUMNS, cols);
        write_reg(REG_ROWS, nrows);
        write_reg(REG_PAGE_SEL, pg);
    endtask

    // Mostly lines of text ended by return and line feed, some cursor moves,
    // and some raw bytes.
    task automatic send_text_mix(input int count);
        int sent;
        int kind;
        int len;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(99);
            if (kind < 55)
            begin
                if (book.columns <= 12 && $urandom_range(1) == 1)
                    len = book.columns + 1;
                else
                    len = $urandom_range(6);
                repeat (len)
                    send_char(8'($urandom_range(8'h20, 8'hff)), 8'($urandom_range(8'hff)));
                send_char(CH_RETURN, 8'($urandom_range(8'hff)));
                send_char(CH_LINEFEED, 8'($urandom_range(8'hff)));
                sent += len + 2;
            end
            else if (kind < 68)
            begin
                len = $urandom_range(1, 4);
                repeat (len)
                    send_char(CH_BACKSPACE, 8'($urandom_range(8'hff)));
                sent += len;
            end
            else if (kind < 80)
            begin
                len = $urandom_range(1, 4);
                repeat (len)
                    send_char(CH_LINEFEED, 8'($urandom_range(8'hff)));
                sent += len;
            end
            else if (kind < 85)
            begin
                send_char(CH_BELL, 8'($urandom_range(8'hff)));
                sent++;
            end
            else
            begin
                send_char(8'($urandom_range(8'hff)), 8'($urandom_range(8'hff)));
                sent++;
            end
        end
    endtask

    initial
    begin
        book = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        character = '0;
        attribute = '0;
        out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (12)
            @(negedge clk);
        rst_n <= 1'b1;

        // Reset geometry: every code kind and the byte extremes.
        send_char(CH_BELL, 8'hff);
        send_char(CH_BACKSPACE, 8'h00);
        send_char(8'hff, 8'h00);
        send_char(8'h00, 8'hff);
        send_char(8'h55, 8'haa);
        send_char(8'haa, 8'h55);
        send_char(CH_BACKSPACE, 8'h12);
        send_char(CH_RETURN, 8'h34);
        send_char(CH_LINEFEED, 8'h56);

        // Tiny page beyond the end of the store: writes and scroll reads fall
        // outside the store, and wrapping past the last row scrolls.
        configure(3, 2, 7);
        send_char("a", 8'h1f);
        send_char("b", 8'h2e);
        send_char("c", 8'h3d);
        send_char("d", 8'h4c);
        send_char("e", 8'h5b);
        send_char("f", 8'h6a);
        send_char(CH_LINEFEED, 8'h07);
        send_char(CH_BACKSPACE, 8'h07);

        // Zero sizes act as one; the stored cursor is now outside the page.
        configure(0, 0, 7);
        send_char("z", 8'h70);
        send_char(CH_LINEFEED, 8'h07);
        send_char(CH_RETURN, 8'h07);

        // Narrow pages with a single row.
        configure(32'(NARROW_COLUMNS), 1, 6);
        send_char("q", 8'h0f);
        send_char(CH_LINEFEED, 8'h07);
        send_char(CH_BACKSPACE, 8'h07);

        // Widest register values: run the cursor down to the last row, which
        // then scrolls the largest page.
        configure(127, 31, 2);
        set_idle(NO_IDLE);
        repeat (31)
            send_char(CH_LINEFEED, 8'($urandom_range(8'hff)));
        repeat (4)
            send_char(8'($urandom_range(8'h20, 8'hff)), 8'($urandom_range(8'hff)));
        send_char(CH_BACKSPACE, 8'($urandom_range(8'hff)));
        send_char(CH_RETURN, 8'($urandom_range(8'hff)));

        for (int p = 0; p < 12; p++)
        begin
            if (p == 5)
                configure(32'(COLUMNS_RESET), 32'(ROWS_RESET), 0);
            else if (p == 3 || p == 9)
                configure(32'(NARROW_COLUMNS), $urandom_range(6), $urandom_range(7));
            else
                configure($urandom_range(12), $urandom_range(6), $urandom_range(7));
            set_idle(idle_mode_t'(p % 4));
            send_text_mix(5);
        end

        drain();
        repeat (16)
            @(posedge clk);
        if (book.errors == 0 && book.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

[sim.f]
sv/tct_pkg.sv
sv/tct_ctrl.sv
sv/tct_datapath.sv
sv/text_console_teletype.sv
sv/tct_checker.sv
tb/text_console_teletype_tb.sv
